// File: rtl/core/memory_scan_compare_filter_macros.svh
// Assertion helpers for the scan filter; clk and rst_n come from the using module.
`ifndef MEMORY_SCAN_COMPARE_FILTER_MACROS_SVH
`define MEMORY_SCAN_COMPARE_FILTER_MACROS_SVH

`define MSC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MSC_ASSERT_NEVER(lbl, cond, msg) \
  `MSC_ASSERT_IMPLIES(lbl, 1'b1, !(cond), msg)

`endif

// File: rtl/core/msc_pkg.sv
package msc_pkg;

  typedef enum logic [2:0] {
    VT_U8  = 3'd0,
    VT_U16 = 3'd1,
    VT_U32 = 3'd2,
    VT_U64 = 3'd3,
    VT_F32 = 3'd4,
    VT_F64 = 3'd5
  } vtype_t;

  typedef enum logic [3:0] {
    CM_EQ        = 4'd0,
    CM_NE        = 4'd1,
    CM_GT        = 4'd2,
    CM_LT        = 4'd3,
    CM_CHANGED   = 4'd4,
    CM_UNCHANGED = 4'd5,
    CM_INCREASED = 4'd6,
    CM_DECREASED = 4'd7,
    CM_RELATIVE  = 4'd8,
    CM_EPSILON   = 4'd9
  } cmode_t;

  localparam logic [3:0] REG_VALUE_TYPE   = 4'd0;
  localparam logic [3:0] REG_COMPARE_MODE = 4'd1;
  localparam logic [3:0] REG_REFERENCE    = 4'd2;
  localparam logic [3:0] REG_EPSILON      = 4'd3;
  localparam logic [3:0] REG_RELATIVE     = 4'd4;
  localparam logic [3:0] REG_RESCAN       = 4'd5;
  localparam logic [3:0] REG_RANGE_BEGIN  = 4'd6;
  localparam logic [3:0] REG_RANGE_END    = 4'd7;

  localparam int WIDEN_STAGES = 2;
  localparam int BAND_STAGES  = 6;
  localparam int PIPE_STAGES  = WIDEN_STAGES + BAND_STAGES;

  localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;

  function automatic logic [63:0] type_mask(vtype_t t);
    logic [63:0] m;
    case (t) inside
      VT_U8:          m = 64'h0000_0000_0000_00FF;
      VT_U16:         m = 64'h0000_0000_0000_FFFF;
      VT_U32, VT_F32: m = 64'h0000_0000_FFFF_FFFF;
      default:        m = '1;
    endcase
    return m;
  endfunction

  // low address bits that must be zero for a naturally aligned value
  function automatic logic [2:0] align_mask(vtype_t t);
    logic [2:0] m;
    case (t) inside
      VT_U8:          m = 3'd0;
      VT_U16:         m = 3'd1;
      VT_U32, VT_F32: m = 3'd3;
      default:        m = 3'd7;
    endcase
    return m;
  endfunction

  function automatic logic vt_known(vtype_t t);
    return t <= VT_F64;
  endfunction

  // leading zero count, 128 for an all-zero word
  function automatic logic [7:0] lzc128(logic [127:0] x);
    logic [7:0] n;
    n = 8'd128;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) n = 8'(127 - i);
    end
    return n;
  endfunction

  function automatic logic dbl_nan(logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic dbl_eq(logic [63:0] a, logic [63:0] b);
    return !dbl_nan(a) && !dbl_nan(b) &&
           ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
  endfunction

  // monotone unsigned key for ordered compare
  function automatic logic [63:0] dbl_key(logic [63:0] x);
    return x[63] ? ~x : {1'b1, x[62:0]};
  endfunction

  function automatic logic dbl_lt(logic [63:0] a, logic [63:0] b);
    return !dbl_nan(a) && !dbl_nan(b) && !dbl_eq(a, b) && (dbl_key(a) < dbl_key(b));
  endfunction

  function automatic logic dbl_le(logic [63:0] a, logic [63:0] b);
    return dbl_eq(a, b) || dbl_lt(a, b);
  endfunction

endpackage

// File: rtl/core/memory_scan_compare_filter.sv
// Memory scan compare filter.
// Requests enter on start with in_word_address, in_raw_data, in_read_valid and
// in_previous_data; busy stays low, so a request is taken on every cycle start is high.
// The typed value is widened to double and compared with the reference under the
// programmed mode; a hit gives one out_valid strobe with out_match_address and
// out_match_value. Dropped requests give nothing.
// Pipeline: nine register stages lie between the accepting edge and out_valid:
// two for widening, six for the parallel subtract and multiply datapaths, one
// output register. Throughput is one request per
// cycle; the six-stage double subtract and 53x53 multiply set the depth.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index;
// cfg_ready is always high. Write only while no requests are in flight.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and loads register
// defaults. The receiver cannot stall; each result is shown for one cycle only.
`include "memory_scan_compare_filter_macros.svh"

module memory_scan_compare_filter import msc_pkg::*; #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_word_address,
  input  logic [63:0] in_raw_data,
  input  logic        in_read_valid,
  input  logic [63:0] in_previous_data,
  output logic        out_valid,
  output logic [31:0] out_match_address,
  output logic [63:0] out_match_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [31:0] ADDR_MASK = 32'((65'd1 << ADDRESS_BITS) - 65'd1);
  localparam int          LATENCY   = PIPE_STAGES + 1;

  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cmp_t;

  // configuration registers
  vtype_t      value_type_r;
  cmode_t      compare_mode_r;
  logic [63:0] reference_bits_r, epsilon_bits_r, relative_bits_r;
  logic        rescan_mode_r;
  logic [31:0] range_begin_r, range_end_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_type_r     <= VT_U32;
      compare_mode_r   <= CM_EQ;
      reference_bits_r <= 64'd0;
      epsilon_bits_r   <= 64'd0;
      relative_bits_r  <= 64'd0;
      rescan_mode_r    <= 1'b0;
      range_begin_r    <= 32'd0;
      range_end_r      <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VALUE_TYPE:   value_type_r     <= vtype_t'(cfg_data[2:0]);
        REG_COMPARE_MODE: compare_mode_r   <= cmode_t'(cfg_data[3:0]);
        REG_REFERENCE:    reference_bits_r <= cfg_data;
        REG_EPSILON:      epsilon_bits_r   <= cfg_data;
        REG_RELATIVE:     relative_bits_r  <= cfg_data;
        REG_RESCAN:       rescan_mode_r    <= cfg_data[0];
        REG_RANGE_BEGIN:  range_begin_r    <= cfg_data[31:0];
        REG_RANGE_END:    range_end_r      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // entry filter
  logic        accept, change_mode, aligned, in_range, keep;
  logic [31:0] addr_m;
  logic [63:0] ref_raw;

  always_comb begin
    accept      = start & ~busy;
    addr_m      = in_word_address & ADDR_MASK;
    change_mode = compare_mode_r inside {CM_CHANGED, CM_UNCHANGED, CM_INCREASED,
                                         CM_DECREASED};
    aligned     = (addr_m[2:0] & align_mask(value_type_r)) == 3'd0;
    in_range    = (addr_m >= range_begin_r) && (addr_m < range_end_r);
    keep        = in_read_valid && vt_known(value_type_r) &&
                  (rescan_mode_r || (aligned && in_range));
    ref_raw     = (rescan_mode_r && change_mode) ? in_previous_data : reference_bits_r;
  end

  // valid and payload travel alongside the datapath
  logic        pv_r    [PIPE_STAGES];
  logic [31:0] paddr_r [PIPE_STAGES];
  logic [63:0] praw_r  [PIPE_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_STAGES; i++) pv_r[i] <= 1'b0;
    end else begin
      pv_r[0] <= accept & keep;
      for (int i = 1; i < PIPE_STAGES; i++) pv_r[i] <= pv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    paddr_r[0] <= addr_m;
    praw_r[0]  <= in_raw_data;
    for (int i = 1; i < PIPE_STAGES; i++) begin
      paddr_r[i] <= paddr_r[i-1];
      praw_r[i]  <= praw_r[i-1];
    end
  end

  logic [63:0] cur_dbl, ref_dbl, abs_diff, abs_prod;

  msc_widen u_widen_cur (
    .clk   (clk),
    .vtype (value_type_r),
    .raw   (in_raw_data),
    .dbl   (cur_dbl)
  );

  msc_widen u_widen_ref (
    .clk   (clk),
    .vtype (value_type_r),
    .raw   (ref_raw),
    .dbl   (ref_dbl)
  );

  msc_band u_band (
    .clk      (clk),
    .cur_dbl  (cur_dbl),
    .ref_dbl  (ref_dbl),
    .rel_dbl  (relative_bits_r),
    .abs_diff (abs_diff),
    .abs_prod (abs_prod)
  );

  // ordered compares, delayed to line up with the band datapath
  cmp_t cmp_r [BAND_STAGES];

  always_ff @(posedge clk) begin
    cmp_r[0].eq <= dbl_eq(cur_dbl, ref_dbl);
    cmp_r[0].lt <= dbl_lt(cur_dbl, ref_dbl);
    cmp_r[0].gt <= dbl_lt(ref_dbl, cur_dbl);
    for (int i = 1; i < BAND_STAGES; i++) cmp_r[i] <= cmp_r[i-1];
  end

  logic match;
  cmp_t cmp_last;

  always_comb begin
    cmp_last = cmp_r[BAND_STAGES-1];
    case (compare_mode_r) inside
      CM_EQ, CM_UNCHANGED: match = cmp_last.eq;
      CM_NE, CM_CHANGED:   match = !cmp_last.eq;
      CM_GT, CM_INCREASED: match = cmp_last.gt;
      CM_LT, CM_DECREASED: match = cmp_last.lt;
      CM_RELATIVE:         match = dbl_le(abs_diff, abs_prod);
      CM_EPSILON:          match = dbl_le(abs_diff, epsilon_bits_r);
      default:             match = 1'b0;
    endcase
  end

  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [63:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pv_r[PIPE_STAGES-1] & match;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r  <= paddr_r[PIPE_STAGES-1];
    out_value_r <= praw_r[PIPE_STAGES-1] & type_mask(value_type_r);
  end

  assign out_valid         = out_valid_r;
  assign out_match_address = out_addr_r;
  assign out_match_value   = out_value_r;

  `MSC_ASSERT_NEVER(a_result_needs_request, out_valid && !$past(start, LATENCY), "result without request")
  `MSC_ASSERT_IMPLIES(a_result_read_ok, out_valid, $past(in_read_valid, LATENCY), "result from failed read")
  `MSC_ASSERT_IMPLIES(a_result_address, out_valid, out_match_address == ($past(in_word_address, LATENCY) & ADDR_MASK), "result address mismatch")

endmodule

// File: rtl/core/msc_widen.sv
module msc_widen import msc_pkg::*; (
  input  logic        clk,
  input  vtype_t      vtype,
  input  logic [63:0] raw,
  output logic [63:0] dbl
);

  // stage A: classify, pick integer magnitude, count leading zeros
  logic [63:0] v;
  logic [63:0] direct_nxt, direct_r;
  logic        is_direct_nxt, is_direct_r;
  logic        sign_nxt, sign_r;
  logic        sub_nxt, sub_r;
  logic [63:0] mag_nxt, mag_r;
  logic [7:0]  lz_full;
  logic [6:0]  lz_r;
  logic        zero_r;

  always_comb begin
    v             = raw & type_mask(vtype);
    direct_nxt    = v;
    is_direct_nxt = 1'b0;
    sign_nxt      = 1'b0;
    sub_nxt       = 1'b0;
    mag_nxt       = v;
    case (vtype)
      VT_F32: begin
        sign_nxt = v[31];
        mag_nxt  = {41'd0, v[22:0]};
        if (v[30:23] == 8'hFF) begin
          is_direct_nxt = 1'b1;
          direct_nxt    = {v[31], 11'h7FF, v[22:0], 29'd0};
        end else if (v[30:23] == 8'd0) begin
          if (v[22:0] == 23'd0) begin
            is_direct_nxt = 1'b1;
            direct_nxt    = {v[31], 63'd0};
          end else begin
            sub_nxt = 1'b1;   // f32 denormal goes through the integer normalizer
          end
        end else begin
          is_direct_nxt = 1'b1;
          direct_nxt    = {v[31], {3'd0, v[30:23]} + 11'd896, v[22:0], 29'd0};
        end
      end
      VT_F64: begin
        is_direct_nxt = 1'b1;
      end
      default: ;
    endcase
    lz_full = lzc128({mag_nxt, 64'd0});
  end

  always_ff @(posedge clk) begin
    direct_r    <= direct_nxt;
    is_direct_r <= is_direct_nxt;
    sign_r      <= sign_nxt;
    sub_r       <= sub_nxt;
    mag_r       <= mag_nxt;
    lz_r        <= lz_full[6:0];
    zero_r      <= (mag_nxt == 64'd0);
  end

  // stage B: normalize and round to nearest even
  logic [63:0] norm;
  logic        up;
  logic [52:0] frac;
  logic [10:0] exp_b;
  logic [63:0] dbl_nxt, dbl_r;

  always_comb begin
    norm  = mag_r << lz_r;
    up    = norm[10] & ((|norm[9:0]) | norm[11]);
    frac  = {1'b0, norm[62:11]} + {52'd0, up};
    exp_b = 11'd1086 - {4'd0, lz_r} - (sub_r ? 11'd149 : 11'd0) + {10'd0, frac[52]};
    if (is_direct_r) begin
      dbl_nxt = direct_r;
    end else if (zero_r) begin
      dbl_nxt = {sign_r, 63'd0};
    end else begin
      dbl_nxt = {sign_r, exp_b, frac[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    dbl_r <= dbl_nxt;
  end

  assign dbl = dbl_r;

endmodule

// File: rtl/core/msc_band.sv
module msc_band import msc_pkg::*; (
  input  logic        clk,
  input  logic [63:0] cur_dbl,
  input  logic [63:0] ref_dbl,
  input  logic [63:0] rel_dbl,
  output logic [63:0] abs_diff,
  output logic [63:0] abs_prod
);

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } fflags_t;

  // ---------------- |cur - ref| ----------------
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_big;
  logic [10:0] ea, eb, ea_eff, eb_eff;
  logic [52:0] ma, mb;

  logic [52:0] s1_mx_r, s1_my_r;
  logic [10:0] s1_ex_r, s1_d_r;
  logic        s1_sub_r;
  fflags_t     s1_f_r;

  always_comb begin
    sa     = cur_dbl[63];
    sb     = ref_dbl[63];
    ea     = cur_dbl[62:52];
    eb     = ref_dbl[62:52];
    a_nan  = dbl_nan(cur_dbl);
    b_nan  = dbl_nan(ref_dbl);
    a_inf  = (ea == 11'h7FF) && (cur_dbl[51:0] == 52'd0);
    b_inf  = (eb == 11'h7FF) && (ref_dbl[51:0] == 52'd0);
    ma     = {ea != 11'd0, cur_dbl[51:0]};
    mb     = {eb != 11'd0, ref_dbl[51:0]};
    ea_eff = (ea == 11'd0) ? 11'd1 : ea;
    eb_eff = (eb == 11'd0) ? 11'd1 : eb;
    a_big  = cur_dbl[62:0] >= ref_dbl[62:0];
  end

  always_ff @(posedge clk) begin
    s1_mx_r     <= a_big ? ma : mb;
    s1_my_r     <= a_big ? mb : ma;
    s1_ex_r     <= a_big ? ea_eff : eb_eff;
    s1_d_r      <= a_big ? (ea_eff - eb_eff) : (eb_eff - ea_eff);
    s1_sub_r    <= (sa == sb);
    s1_f_r.nan  <= a_nan | b_nan | (a_inf & b_inf & (sa == sb));
    s1_f_r.inf  <= a_inf | b_inf;
    s1_f_r.zero <= 1'b0;
  end

  // align the smaller operand, guard/round/sticky below
  logic [5:0]  s2_sh;
  logic [55:0] s2_ext, s2_shifted, s2_mask;
  logic [52:0] s2_mx_r;
  logic [55:0] s2_my_r;
  logic [10:0] s2_ex_r;
  logic        s2_sub_r;
  fflags_t     s2_f_r;

  always_comb begin
    s2_sh      = (s1_d_r >= 11'd56) ? 6'd56 : s1_d_r[5:0];
    s2_ext     = {s1_my_r, 3'd0};
    s2_shifted = s2_ext >> s2_sh;
    s2_mask    = (56'd1 << s2_sh) - 56'd1;
  end

  always_ff @(posedge clk) begin
    s2_mx_r  <= s1_mx_r;
    s2_my_r  <= {s2_shifted[55:1], s2_shifted[0] | (|(s2_ext & s2_mask))};
    s2_ex_r  <= s1_ex_r;
    s2_sub_r <= s1_sub_r;
    s2_f_r   <= s1_f_r;
  end

  logic [56:0] s3_sum_r;
  logic [10:0] s3_ex_r;
  fflags_t     s3_f_r;

  always_ff @(posedge clk) begin
    s3_sum_r <= s2_sub_r ? ({1'b0, s2_mx_r, 3'd0} - {1'b0, s2_my_r})
                         : ({1'b0, s2_mx_r, 3'd0} + {1'b0, s2_my_r});
    s3_ex_r  <= s2_ex_r;
    s3_f_r   <= s2_f_r;
  end

  // leading zeros, limited so the exponent stays at the denormal floor
  logic [7:0]  s4_lz;
  logic [10:0] s4_room;
  logic [55:0] s4_pre_nxt, s4_pre_r;
  logic [11:0] s4_e_nxt, s4_e_r;
  logic [5:0]  s4_shl_nxt, s4_shl_r;
  fflags_t     s4_f_r;

  always_comb begin
    s4_lz   = lzc128({s3_sum_r[55:0], 72'd0});
    s4_room = s3_ex_r - 11'd1;
    if (s3_sum_r[56]) begin
      s4_pre_nxt = {s3_sum_r[56:2], s3_sum_r[1] | s3_sum_r[0]};
      s4_e_nxt   = {1'b0, s3_ex_r} + 12'd1;
      s4_shl_nxt = 6'd0;
    end else begin
      s4_pre_nxt = s3_sum_r[55:0];
      s4_e_nxt   = {1'b0, s3_ex_r};
      s4_shl_nxt = ({3'd0, s4_lz} < s4_room) ? s4_lz[5:0] : s4_room[5:0];
    end
  end

  always_ff @(posedge clk) begin
    s4_pre_r <= s4_pre_nxt;
    s4_e_r   <= s4_e_nxt;
    s4_shl_r <= s4_shl_nxt;
    s4_f_r   <= s3_f_r;
  end

  logic [55:0] s5_nrm_r;
  logic [11:0] s5_e_r;
  fflags_t     s5_f_r;

  always_ff @(posedge clk) begin
    s5_nrm_r <= s4_pre_r << s4_shl_r;
    s5_e_r   <= s4_e_r - {6'd0, s4_shl_r};
    s5_f_r   <= s4_f_r;
  end

  logic        s6_up;
  logic [53:0] s6_m;
  logic [11:0] s6_fexp;
  logic [51:0] s6_frac;
  logic [63:0] s6_out_nxt, s6_out_r;

  always_comb begin
    s6_up = s5_nrm_r[2] & ((|s5_nrm_r[1:0]) | s5_nrm_r[3]);
    s6_m  = {1'b0, s5_nrm_r[55:3]} + {53'd0, s6_up};
    if (s6_m[53]) begin
      s6_fexp = s5_e_r + 12'd1;
      s6_frac = s6_m[52:1];
    end else begin
      s6_fexp = s6_m[52] ? s5_e_r : 12'd0;
      s6_frac = s6_m[51:0];
    end
    if (s5_f_r.nan) begin
      s6_out_nxt = DBL_QNAN;
    end else if (s5_f_r.inf || (s6_fexp >= 12'd2047)) begin
      s6_out_nxt = DBL_INF;
    end else begin
      s6_out_nxt = {1'b0, s6_fexp[10:0], s6_frac};
    end
  end

  always_ff @(posedge clk) begin
    s6_out_r <= s6_out_nxt;
  end

  assign abs_diff = s6_out_r;

  // ---------------- |ref * rel| ----------------
  logic        pa_nan, pb_nan, pa_inf, pb_inf, pa_zero, pb_zero;
  logic [10:0] pea, peb;
  logic [52:0] pma, pmb;

  logic [53:0] m1_ll_r;
  logic [52:0] m1_lh_r, m1_hl_r;
  logic [51:0] m1_hh_r;
  logic [11:0] m1_esum_r;
  fflags_t     m1_f_r;

  always_comb begin
    pea     = ref_dbl[62:52];
    peb     = rel_dbl[62:52];
    pa_nan  = dbl_nan(ref_dbl);
    pb_nan  = dbl_nan(rel_dbl);
    pa_inf  = (pea == 11'h7FF) && (ref_dbl[51:0] == 52'd0);
    pb_inf  = (peb == 11'h7FF) && (rel_dbl[51:0] == 52'd0);
    pa_zero = (ref_dbl[62:0] == 63'd0);
    pb_zero = (rel_dbl[62:0] == 63'd0);
    pma     = {pea != 11'd0, ref_dbl[51:0]};
    pmb     = {peb != 11'd0, rel_dbl[51:0]};
  end

  // four partial products of the 27-bit low and 26-bit high mantissa halves
  always_ff @(posedge clk) begin
    m1_ll_r     <= {27'd0, pma[26:0]}  * {27'd0, pmb[26:0]};
    m1_lh_r     <= {26'd0, pma[26:0]}  * {27'd0, pmb[52:27]};
    m1_hl_r     <= {27'd0, pma[52:27]} * {26'd0, pmb[26:0]};
    m1_hh_r     <= {26'd0, pma[52:27]} * {26'd0, pmb[52:27]};
    m1_esum_r   <= {1'b0, (pea == 11'd0) ? 11'd1 : pea}
                 + {1'b0, (peb == 11'd0) ? 11'd1 : peb};
    m1_f_r.nan  <= pa_nan | pb_nan | (pa_inf & pb_zero) | (pa_zero & pb_inf);
    m1_f_r.inf  <= pa_inf | pb_inf;
    m1_f_r.zero <= pa_zero | pb_zero;
  end

  logic [53:0]  m2_mid_r;
  logic [105:0] m2_outer_r;
  logic [11:0]  m2_esum_r;
  fflags_t      m2_f_r;

  always_ff @(posedge clk) begin
    m2_mid_r   <= {1'b0, m1_lh_r} + {1'b0, m1_hl_r};
    m2_outer_r <= {m1_hh_r, m1_ll_r};
    m2_esum_r  <= m1_esum_r;
    m2_f_r     <= m1_f_r;
  end

  logic [105:0] m3_p_r;
  logic [11:0]  m3_esum_r;
  fflags_t      m3_f_r;

  always_ff @(posedge clk) begin
    m3_p_r    <= m2_outer_r + {25'd0, m2_mid_r, 27'd0};
    m3_esum_r <= m2_esum_r;
    m3_f_r    <= m2_f_r;
  end

  // right shift that keeps 53 bits, or lands on the denormal floor
  logic [7:0]         m4_lz;
  logic signed [13:0] m4_r1, m4_r2, m4_rmax, m4_rc;
  logic [6:0]         m4_r_nxt, m4_r_r;
  logic signed [13:0] m4_bexp_nxt, m4_bexp_r;
  logic [105:0]       m4_p_r;
  fflags_t            m4_f_r;

  always_comb begin
    m4_lz   = lzc128({m3_p_r, 22'd0});
    m4_r1   = 14'sd53 - $signed({6'd0, m4_lz});
    m4_r2   = 14'sd1076 - $signed({2'd0, m3_esum_r});
    m4_rmax = (m4_r1 > m4_r2) ? m4_r1 : m4_r2;
    if (m4_rmax < 14'sd0) begin
      m4_rc = 14'sd0;
    end else if (m4_rmax > 14'sd108) begin
      m4_rc = 14'sd108;
    end else begin
      m4_rc = m4_rmax;
    end
    m4_r_nxt    = m4_rc[6:0];
    m4_bexp_nxt = $signed({7'd0, m4_r_nxt}) + $signed({2'd0, m3_esum_r}) - 14'sd1075;
  end

  always_ff @(posedge clk) begin
    m4_p_r    <= m3_p_r;
    m4_r_r    <= m4_r_nxt;
    m4_bexp_r <= m4_bexp_nxt;
    m4_f_r    <= m3_f_r;
  end

  logic [107:0]       m5_ext, m5_q, m5_mask;
  logic [52:0]        m5_mant_r;
  logic               m5_g_r, m5_st_r;
  logic signed [13:0] m5_bexp_r;
  fflags_t            m5_f_r;

  always_comb begin
    m5_ext  = {m4_p_r, 2'd0};
    m5_q    = m5_ext >> m4_r_r;
    m5_mask = (108'd1 << m4_r_r) - 108'd1;
  end

  always_ff @(posedge clk) begin
    m5_mant_r <= m5_q[54:2];
    m5_g_r    <= m5_q[1];
    m5_st_r   <= m5_q[0] | (|(m5_ext & m5_mask));
    m5_bexp_r <= m4_bexp_r;
    m5_f_r    <= m4_f_r;
  end

  logic               m6_up;
  logic [53:0]        m6_m;
  logic signed [13:0] m6_fexp;
  logic [51:0]        m6_frac;
  logic [63:0]        m6_out_nxt, m6_out_r;

  always_comb begin
    m6_up = m5_g_r & (m5_st_r | m5_mant_r[0]);
    m6_m  = {1'b0, m5_mant_r} + {53'd0, m6_up};
    if (m6_m[53]) begin
      m6_fexp = m5_bexp_r + 14'sd1;
      m6_frac = m6_m[52:1];
    end else begin
      m6_fexp = m6_m[52] ? m5_bexp_r : 14'sd0;
      m6_frac = m6_m[51:0];
    end
    if (m5_f_r.nan) begin
      m6_out_nxt = DBL_QNAN;
    end else if (m5_f_r.inf || (m6_fexp >= 14'sd2047)) begin
      m6_out_nxt = DBL_INF;
    end else if (m5_f_r.zero) begin
      m6_out_nxt = 64'd0;
    end else begin
      m6_out_nxt = {1'b0, m6_fexp[10:0], m6_frac};
    end
  end

  always_ff @(posedge clk) begin
    m6_out_r <= m6_out_nxt;
  end

  assign abs_prod = m6_out_r;

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msc_pkg::*;

  typedef struct packed {
    logic [31:0] addr;
    logic [63:0] raw;
    logic        valid;
    logic [63:0] prev;
  } scan_word_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [63:0] value;
  } scan_hit_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_word_address = '0;
  logic [63:0] in_raw_data = '0;
  logic        in_read_valid = 1'b0;
  logic [63:0] in_previous_data = '0;
  logic        out_valid;
  logic [31:0] out_match_address;
  logic [63:0] out_match_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  memory_scan_compare_filter u_dut (
    .clk, .rst_n, .start, .busy,
    .in_word_address, .in_raw_data, .in_read_valid, .in_previous_data,
    .out_valid, .out_match_address, .out_match_value,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // shadow copy of the filter registers
  logic [2:0]  sh_type = 3'd2;
  logic [3:0]  sh_mode = 4'd0;
  logic [63:0] sh_ref = '0;
  logic [63:0] sh_eps = '0;
  logic [63:0] sh_rel = '0;
  logic        sh_rescan = 1'b0;
  logic [31:0] sh_begin = '0;
  logic [31:0] sh_end = '0;

  scan_word_t scan_q[$];
  scan_hit_t  hit_q[$];
  int         idle_pct = 0;
  int         errors = 0;
  int         n_sent = 0;
  int         n_hits = 0;
  int         n_cfg = 0;
  int         idle_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] width_mask(logic [2:0] t);
    case (t)
      VT_U8:          return 64'hFF;
      VT_U16:         return 64'hFFFF;
      VT_U32, VT_F32: return 64'hFFFF_FFFF;
      default:        return '1;
    endcase
  endfunction

  function automatic logic [31:0] size_of(logic [2:0] t);
    case (t)
      VT_U8:          return 32'd1;
      VT_U16:         return 32'd2;
      VT_U64, VT_F64: return 32'd8;
      default:        return 32'd4;
    endcase
  endfunction

  function automatic real to_double(logic [2:0] t, logic [63:0] raw);
    logic [63:0] v;
    logic [63:0] h;
    real r;
    v = raw & width_mask(t);
    if (t == VT_F64) return $bitstoreal(v);
    if (t == VT_F32) begin
      if (v[30:23] == 8'hFF) return $bitstoreal({v[31], 11'h7FF, v[22:0], 29'd0});
      if (v[30:23] == 8'd0) begin
        // subnormal single: mantissa times 2^-149 is exact in double
        r = real'(longint'({41'd0, v[22:0]})) * $bitstoreal(64'(874) << 52);
        return v[31] ? -r : r;
      end
      return $bitstoreal({v[31], 11'(v[30:23] + 11'd896), v[22:0], 29'd0});
    end
    if (v[63]) begin
      // halve with a sticky bit so the conversion rounds once, correctly
      h = (v >> 1) | (v & 64'd1);
      return real'(longint'(h)) * 2.0;
    end
    return real'(longint'(v));
  endfunction

  function automatic real fabs(real x);
    return (x < 0.0) ? -x : x;
  endfunction

  function automatic bit filter_word(scan_word_t w, output scan_hit_t hit);
    real cur;
    real rv;
    bit ok;
    hit = '0;
    if (!w.valid || sh_type > VT_F64) return 0;
    if (!sh_rescan) begin
      if ((w.addr & (size_of(sh_type) - 32'd1)) != 0) return 0;
      if (w.addr < sh_begin || w.addr >= sh_end) return 0;
    end
    cur = to_double(sh_type, w.raw);
    if (sh_rescan && sh_mode >= CM_CHANGED && sh_mode <= CM_DECREASED)
      rv = to_double(sh_type, w.prev);
    else
      rv = to_double(sh_type, sh_ref);
    case (sh_mode)
      CM_EQ, CM_UNCHANGED:       ok = (cur == rv);
      CM_NE, CM_CHANGED:         ok = (cur != rv);
      CM_GT, CM_INCREASED:       ok = (cur > rv);
      CM_LT, CM_DECREASED:       ok = (cur < rv);
      CM_RELATIVE: ok = fabs(cur - rv) <= fabs(rv * $bitstoreal(sh_rel));
      CM_EPSILON:  ok = fabs(cur - rv) <= $bitstoreal(sh_eps);
      default:     ok = 0;
    endcase
    if (!ok) return 0;
    hit.addr = w.addr;
    hit.value = w.raw & width_mask(sh_type);
    return 1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver: takes requests from scan_q, predicts each accepted one
  always @(posedge clk) begin
    scan_word_t w;
    scan_hit_t hit;
    bit take;
    if (rst_n) begin
      take = 1'b1;
      if (start && !busy) begin
        w = '{in_word_address, in_raw_data, in_read_valid, in_previous_data};
        n_sent++;
        if (filter_word(w, hit)) hit_q.push_back(hit);
      end else if (start) begin
        take = 1'b0;
      end
      if (take) begin
        if (scan_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          w = scan_q.pop_front();
          start <= 1'b1;
          in_word_address <= w.addr;
          in_raw_data <= w.raw;
          in_read_valid <= w.valid;
          in_previous_data <= w.prev;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    scan_hit_t e;
    if (rst_n && out_valid) begin
      if (hit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected match addr %h value %h",
                                  out_match_address, out_match_value));
      end else begin
        e = hit_q.pop_front();
        n_hits++;
        if (out_match_address !== e.addr)
          report_mismatch($sformatf("address %h, want %h", out_match_address, e.addr));
        if (out_match_value !== e.value)
          report_mismatch($sformatf("value %h, want %h (addr %h)",
                                    out_match_value, e.value, e.addr));
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("memory_scan_compare_filter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(logic [31:0] a, logic [63:0] r, logic v, logic [63:0] p);
    scan_word_t w;
    w = '{a, r, v, p};
    scan_q.push_back(w);
  endtask

  task automatic drain();
    @(posedge clk);
    while (scan_q.size() > 0 || start || hit_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    case (idx)
      REG_VALUE_TYPE:   sh_type = d[2:0];
      REG_COMPARE_MODE: sh_mode = d[3:0];
      REG_REFERENCE:    sh_ref = d;
      REG_EPSILON:      sh_eps = d;
      REG_RELATIVE:     sh_rel = d;
      REG_RESCAN:       sh_rescan = d[0];
      REG_RANGE_BEGIN:  sh_begin = d[31:0];
      REG_RANGE_END:    sh_end = d[31:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [2:0] t, logic [3:0] m, logic [63:0] r, logic [63:0] e,
                              logic [63:0] rl, logic rs, logic [31:0] b, logic [31:0] en);
    write_reg(REG_VALUE_TYPE, 64'(t));
    write_reg(REG_COMPARE_MODE, 64'(m));
    write_reg(REG_REFERENCE, r);
    write_reg(REG_EPSILON, e);
    write_reg(REG_RELATIVE, rl);
    write_reg(REG_RESCAN, 64'(rs));
    write_reg(REG_RANGE_BEGIN, 64'(b));
    write_reg(REG_RANGE_END, 64'(en));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_value(logic [2:0] t);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return 64'(($urandom_range(0, 8)));
      3: return r;
      4: begin
        if (t == VT_F32) begin
          case ($urandom_range(0, 4))
            0: return 64'h7FC0_0000;
            1: return 64'hFF80_0000;
            2: return 64'h8000_0000;
            3: return 64'h0000_0001;
            default: return 64'h3F80_0000;
          endcase
        end
        case ($urandom_range(0, 3))
          0: return DBL_QNAN;
          1: return DBL_INF;
          2: return 64'h8000_0000_0000_0000;
          default: return $realtobits(1.0);
        endcase
      end
      5: return $realtobits(real'($urandom_range(0, 20)) - 10.0);
      default: return 64'(($urandom_range(0, 8))) << (8 * $urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [63:0] pick_tol();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return $realtobits(0.5);
      2: return $realtobits(2.0);
      3: return $realtobits(1.0e6);
      4: return DBL_INF;
      5: return DBL_QNAN;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_segment(int count);
    logic [2:0] t;
    logic [3:0] m;
    logic [63:0] r, raw, pv, near;
    logic [31:0] b, en, a;
    int span;
    t = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    m = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    r = pick_value(t);
    case ($urandom_range(0, 3))
      0: begin b = '0; en = '1; end
      1: begin b = $urandom & ~32'd7; en = b; end
      default: begin
        b = $urandom_range(0, 4000) & ~32'd7;
        en = b + $urandom_range(8, 300);
      end
    endcase
    program_regs(t, m, r, pick_tol(), pick_tol(), 1'($urandom_range(0, 1)), b, en);
    span = (en > b && en - b < 1000) ? int'(en - b) + 16 : 1000;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: a = $urandom;
        1: a = b + $urandom_range(0, span) - 8;
        default: a = (b + $urandom_range(0, span)) & ~(size_of(t) - 32'd1);
      endcase
      near = r + 64'($urandom_range(0, 2)) - 64'd1;
      case ($urandom_range(0, 4))
        0, 1: raw = near;
        2: raw = r;
        default: raw = pick_value(t);
      endcase
      // junk above the type width must be ignored
      if ($urandom_range(0, 1)) raw = raw | ({$urandom, $urandom} & ~width_mask(t));
      case ($urandom_range(0, 3))
        0: pv = raw;
        1: pv = raw + 64'd1;
        2: pv = raw - 64'd1;
        default: pv = pick_value(t);
      endcase
      push_word(a, raw, ($urandom_range(0, 9) != 0), pv);
    end
    drain();
  endtask

  initial begin
    int pcts[4];
    pcts = '{0, 80, 0, 22};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: empty range drops everything
    push_word(32'h0, 64'h0, 1'b1, 64'h0);
    push_word(32'hFFFF_FFFC, '1, 1'b1, '1);
    drain();
    // u8 equal over the range 0 to 32'hFFFF_FFFE; the last address falls outside
    program_regs(VT_U8, CM_EQ, 64'h0, '0, '0, 1'b0, 32'h0, 32'hFFFF_FFFF);
    push_word(32'h0, 64'hFFFF_FF00, 1'b1, 64'h0);
    push_word(32'hFFFF_FFFE, 64'h0, 1'b1, 64'h0);
    push_word(32'hFFFF_FFFF, 64'h0, 1'b1, 64'h0);
    push_word(32'h5, 64'hFF, 1'b1, 64'h0);
    push_word(32'h6, 64'h0, 1'b0, 64'h0);
    drain();
    // u16 not-equal over a window: below, misaligned, last, at end
    program_regs(VT_U16, CM_NE, 64'h1, '0, '0, 1'b0, 32'd16, 32'd32);
    push_word(32'd14, 64'hFFFF, 1'b1, 64'h0);
    push_word(32'd16, 64'hFFFF, 1'b1, 64'h0);
    push_word(32'd17, 64'hFFFF, 1'b1, 64'h0);
    push_word(32'd30, 64'h1, 1'b1, 64'h0);
    push_word(32'd32, 64'hFFFF, 1'b1, 64'h0);
    drain();
    // unknown type, then unknown mode
    program_regs(3'd7, CM_EQ, 64'h0, '0, '0, 1'b1, 32'h0, 32'hFFFF_FFFF);
    push_word(32'h8, 64'h0, 1'b1, 64'h0);
    drain();
    program_regs(VT_U32, 4'd15, 64'h0, '0, '0, 1'b1, 32'h0, 32'hFFFF_FFFF);
    push_word(32'h8, 64'h0, 1'b1, 64'h0);
    drain();
    // u64 greater-than near the top, where rounding decides
    program_regs(VT_U64, CM_GT, 64'hFFFF_FFFF_FFFF_FBFF, '0, '0, 1'b0, 32'h0, 32'hFFFF_FFFF);
    push_word(32'h10, '1, 1'b1, 64'h0);
    push_word(32'h18, 64'hFFFF_FFFF_FFFF_FC00, 1'b1, 64'h0);
    drain();
    // f64 epsilon with NaN and infinity
    program_regs(VT_F64, CM_EPSILON, $realtobits(1.0), $realtobits(0.5), '0, 1'b0,
                 32'h0, 32'hFFFF_FFFF);
    push_word(32'h20, $realtobits(1.25), 1'b1, 64'h0);
    push_word(32'h28, DBL_QNAN, 1'b1, 64'h0);
    push_word(32'h30, DBL_INF, 1'b1, 64'h0);
    drain();
    // f32 relative, subnormal and negative zero
    program_regs(VT_F32, CM_RELATIVE, 64'h3F80_0000, '0, $realtobits(0.25), 1'b0,
                 32'h0, 32'hFFFF_FFFF);
    push_word(32'h40, 64'hFFFF_FFFF_3FA0_0000, 1'b1, 64'h0);
    push_word(32'h44, 64'h0000_0001, 1'b1, 64'h0);
    push_word(32'h48, 64'h8000_0000, 1'b1, 64'h0);
    drain();
    // rescan changed: previous value is the reference, no range check
    program_regs(VT_U32, CM_CHANGED, 64'h0, '0, '0, 1'b1, 32'd100, 32'd50);
    push_word(32'h3, 64'h1234, 1'b1, 64'h1234);
    push_word(32'h7, 64'h1234, 1'b1, 64'h1235);
    drain();

    for (int seg = 0; seg < 16; seg++) begin
      idle_pct = pcts[seg % 4];
      random_segment(25);
    end
    idle_pct = 0;
    drain();

    $display("sent %0d scan requests, checked %0d matches, %0d register writes",
             n_sent, n_hits, n_cfg);
    if (errors == 0 && hit_q.size() == 0) begin
      $display("memory_scan_compare_filter regression: pass");
    end else begin
      $display("%0d mismatches, %0d matches outstanding", errors, hit_q.size());
      $display("memory_scan_compare_filter regression: fail");
    end
    $finish;
  end

endmodule
